[design/critical_path_schedule_defines.svh]
// ----------------------------------------------------------------------------
// critical_path_schedule_defines: assertion macros
// Shared checks for the critical path scheduler, clocked on clk and disabled
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CRITICAL_PATH_SCHEDULE_DEFINES_SVH
`define CRITICAL_PATH_SCHEDULE_DEFINES_SVH

// A property that must hold at every clock edge.
`define CPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define CPS_ASSERT_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);

`endif

[design/cps_pkg.sv]
// ----------------------------------------------------------------------------
// cps_pkg: shared definitions of the critical path scheduler
// Field widths, time limit, controller states and the saturating time add.
// ----------------------------------------------------------------------------
package cps_pkg;

	localparam int INDEX_BITS        = 6;
	localparam int DURATION_IN_BITS  = 16;
	localparam int MASK_BITS         = 64;
	localparam int TIME_BITS         = 22;
	localparam int WIDE_BITS         = 32;
	localparam int MAX_TASKS_DEF     = 64;
	localparam int DURATION_BITS_DEF = 16;

	localparam logic [TIME_BITS-1:0] TIME_LIMIT = 22'd4194240;

	typedef enum logic [12:0] {
		ST_LOAD   = 13'b0000000000001,
		ST_FSCAN  = 13'b0000000000010,
		ST_FCHECK = 13'b0000000000100,
		ST_FWALK  = 13'b0000000001000,
		ST_FWEND  = 13'b0000000010000,
		ST_FNEXT  = 13'b0000000100000,
		ST_BORD   = 13'b0000001000000,
		ST_BDUR   = 13'b0000010000000,
		ST_BWALK  = 13'b0000100000000,
		ST_BEND   = 13'b0001000000000,
		ST_OREAD  = 13'b0010000000000,
		ST_OWAIT  = 13'b0100000000000,
		ST_IDLE2  = 13'b1000000000000
	} state_t;

	// Time plus duration, held at the time limit.
	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] t,
			input logic [WIDE_BITS-1:0] d);
		logic [WIDE_BITS:0] s;
		s = (WIDE_BITS+1)'(t) + (WIDE_BITS+1)'(d);
		if (s > (WIDE_BITS+1)'(TIME_LIMIT))
			return TIME_LIMIT;
		return TIME_BITS'(s);
	endfunction

endpackage

[design/cps_task_if.sv]
// ----------------------------------------------------------------------------
// cps_task_if: task load channel
// One beat carries one task: its number, duration and predecessor mask.
// ----------------------------------------------------------------------------
interface cps_task_if;
	logic                                  valid;
	logic                                  ready;
	logic [cps_pkg::INDEX_BITS-1:0]        task_index;
	logic [cps_pkg::DURATION_IN_BITS-1:0]  duration;
	logic [cps_pkg::MASK_BITS-1:0]         pred_mask;
	logic                                  last_task;

	modport source (output valid, task_index, duration, pred_mask, last_task, input ready);
	modport sink (input valid, task_index, duration, pred_mask, last_task, output ready);
endinterface

[design/cps_result_if.sv]
// ----------------------------------------------------------------------------
// cps_result_if: schedule result channel
// One beat carries the start window of one task and the project finish.
// ----------------------------------------------------------------------------
interface cps_result_if;
	logic                           valid;
	logic                           ready;
	logic [cps_pkg::INDEX_BITS-1:0] out_task;
	logic [cps_pkg::TIME_BITS-1:0]  earliest_start;
	logic [cps_pkg::TIME_BITS-1:0]  latest_start;
	logic [cps_pkg::TIME_BITS-1:0]  project_finish;
	logic                           cycle_error;
	logic                           last_result;

	modport source (output valid, out_task, earliest_start, latest_start, project_finish,
		cycle_error, last_result, input ready);
	modport sink (input valid, out_task, earliest_start, latest_start, project_finish,
		cycle_error, last_result, output ready);
endinterface

[design/critical_path_schedule.sv]
// ----------------------------------------------------------------------------
// critical_path_schedule: critical path method over a small project
// Tasks load one per beat on task_in. The beat with last_task set starts the
// computation over tasks 0 up to the highest number loaded. Results leave on
// result_out, one beat per task in task order, the final one with
// last_result set.
// Loading takes one task per cycle. The computation runs on single-port
// memories: the forward pass scans the tasks in repeated passes, and each
// task that becomes ready walks all N entries of the timing memories. The
// backward pass walks all N entries for each task, and the output reads
// each result from memory before placing it in the output register.
// During computation task_in is not ready. After the last result is placed in
// the output register new tasks are taken while that result waits. A stalled
// receiver holds the output register and the result sequence.
// After reset the block is empty and ready for tasks. The memories have no
// reset; a task never loaded must not lie inside the project.
// ----------------------------------------------------------------------------
`include "critical_path_schedule_defines.svh"

module critical_path_schedule #(
	parameter int MAX_TASKS     = cps_pkg::MAX_TASKS_DEF,
	parameter int DURATION_BITS = cps_pkg::DURATION_BITS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	cps_task_if.sink           task_in,
	cps_result_if.source       result_out
);

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int TW    = cps_pkg::TIME_BITS;
	localparam int WW    = cps_pkg::WIDE_BITS;

	// Memories.
	logic [cps_pkg::MASK_BITS-1:0] pred_mem [MAX_TASKS];
	logic [DURATION_BITS-1:0]      dur_mem  [MAX_TASKS];
	logic [TW-1:0]                 est_mem  [MAX_TASKS];
	logic [TW-1:0]                 lst_mem  [MAX_TASKS];
	logic [IDX_W-1:0]              ord_mem  [MAX_TASKS];

	logic [cps_pkg::MASK_BITS-1:0] pred_rd;
	logic [DURATION_BITS-1:0]      dur_rd;
	logic [TW-1:0]                 est_rd;
	logic [TW-1:0]                 lst_rd;
	logic [IDX_W-1:0]              ord_rd;

	logic                 pred_re, dur_re, est_re, lst_re, ord_re;
	logic [IDX_W-1:0]     pred_ra, dur_ra, est_ra, lst_ra;
	logic                 load_we, est_we, lst_we;

	// Control state.
	cps_pkg::state_t       state_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      placed_q;
	logic [IDX_W-1:0]      i_q;
	logic [IDX_W-1:0]      k_q;
	logic [IDX_W-1:0]      p_q;
	logic [IDX_W-1:0]      t_q;
	logic [MAX_TASKS-1:0]  done_q;
	logic [MAX_TASKS-1:0]  preds_q;
	logic                  progress_q;
	logic                  cyc_q;
	logic [TW-1:0]         finish_q;
	logic [TW-1:0]         acc_q;
	logic [DURATION_BITS-1:0] dur_i_q;
	logic                  walk_v_s1;
	logic                  hit_s1;

	// Output register.
	logic                  out_v_q;
	logic [cps_pkg::INDEX_BITS-1:0] out_task_q;
	logic [TW-1:0]         out_est_q, out_lst_q, out_fin_q;
	logic                  out_cyc_q, out_last_q;

	logic                  in_fire, idx_ok;
	logic [CNT_W-1:0]      idx_cnt, count_new;
	logic [MAX_TASKS-1:0]  valid_c, pred_cut, preds_elig;
	logic                  i_last, k_last, eligible, out_load;
	logic [TW-1:0]         fwd_ef, acc_next, ef_i, lst_val;
	logic                  bwd_phase;

	assign task_in.ready = (state_q == cps_pkg::ST_LOAD);
	assign in_fire       = task_in.valid && task_in.ready;
	assign idx_ok        = (7'(task_in.task_index) < 7'(MAX_TASKS));
	assign idx_cnt       = CNT_W'(task_in.task_index) + CNT_W'(1);
	assign count_new     = (idx_cnt > count_q) ? idx_cnt : count_q;
	assign load_we       = in_fire && idx_ok;

	always_comb begin
		for (int b = 0; b < MAX_TASKS; b++) begin
			valid_c[b] = (CNT_W'(b) < n_q);
		end
	end

	assign pred_cut   = pred_rd[MAX_TASKS-1:0];
	assign preds_elig = pred_cut & valid_c;
	assign i_last     = ((CNT_W'(i_q) + CNT_W'(1)) == n_q);
	assign k_last     = ((CNT_W'(k_q) + CNT_W'(1)) == n_q);
	assign eligible   = !done_q[i_q] && ((preds_elig & ~done_q) == '0);
	assign bwd_phase  = (state_q == cps_pkg::ST_BWALK) || (state_q == cps_pkg::ST_BEND);

	// Walk accumulator: longest finish of predecessors going forward, smallest
	// latest start of successors going backward.
	assign fwd_ef = cps_pkg::sat_add(est_rd, WW'(dur_rd));
	always_comb begin
		acc_next = acc_q;
		if (walk_v_s1) begin
			if (bwd_phase) begin
				if (pred_cut[t_q] && (lst_rd < acc_q))
					acc_next = lst_rd;
			end else begin
				if (hit_s1 && (fwd_ef > acc_q))
					acc_next = fwd_ef;
			end
		end
	end

	assign ef_i    = cps_pkg::sat_add(acc_next, WW'(dur_i_q));
	assign lst_val = (WW'(acc_next) > WW'(dur_rd)) ? TW'(WW'(acc_next) - WW'(dur_rd)) : '0;
	assign out_load = (state_q == cps_pkg::ST_OWAIT) && (!out_v_q || result_out.ready);

	// Memory port control.
	always_comb begin
		pred_re = 1'b0;
		dur_re  = 1'b0;
		est_re  = 1'b0;
		lst_re  = 1'b0;
		ord_re  = 1'b0;
		pred_ra = i_q;
		dur_ra  = i_q;
		est_ra  = i_q;
		lst_ra  = i_q;
		unique case (state_q)
			cps_pkg::ST_FSCAN: begin
				pred_re = 1'b1;
				dur_re  = 1'b1;
			end
			cps_pkg::ST_FWALK: begin
				dur_re = 1'b1;
				est_re = 1'b1;
				dur_ra = k_q;
				est_ra = k_q;
			end
			cps_pkg::ST_BORD: ord_re = 1'b1;
			cps_pkg::ST_BDUR: begin
				dur_re = 1'b1;
				dur_ra = ord_rd;
			end
			cps_pkg::ST_BWALK: begin
				pred_re = 1'b1;
				lst_re  = 1'b1;
				pred_ra = k_q;
				lst_ra  = k_q;
			end
			cps_pkg::ST_OREAD: begin
				est_re = 1'b1;
				lst_re = 1'b1;
			end
			default: ;
		endcase
	end

	assign est_we = (state_q == cps_pkg::ST_FWEND);
	assign lst_we = (state_q == cps_pkg::ST_BEND);

	always_ff @(posedge clk) begin
		if (load_we) begin
			pred_mem[task_in.task_index[IDX_W-1:0]] <= task_in.pred_mask;
			dur_mem[task_in.task_index[IDX_W-1:0]]  <= DURATION_BITS'(task_in.duration);
		end
		if (pred_re)
			pred_rd <= pred_mem[pred_ra];
		if (dur_re)
			dur_rd <= dur_mem[dur_ra];
	end

	always_ff @(posedge clk) begin
		if (est_we) begin
			est_mem[i_q]                    <= acc_next;
			ord_mem[placed_q[IDX_W-1:0]]    <= i_q;
		end
		if (est_re)
			est_rd <= est_mem[est_ra];
		if (ord_re)
			ord_rd <= ord_mem[p_q];
	end

	always_ff @(posedge clk) begin
		if (lst_we)
			lst_mem[t_q] <= lst_val;
		if (lst_re)
			lst_rd <= lst_mem[lst_ra];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cps_pkg::ST_LOAD;
			n_q        <= '0;
			count_q    <= '0;
			placed_q   <= '0;
			i_q        <= '0;
			k_q        <= '0;
			p_q        <= '0;
			done_q     <= '0;
			progress_q <= 1'b0;
			cyc_q      <= 1'b0;
			walk_v_s1  <= 1'b0;
		end else begin
			walk_v_s1 <= (state_q == cps_pkg::ST_FWALK) || (state_q == cps_pkg::ST_BWALK);
			unique case (state_q)
				cps_pkg::ST_LOAD: begin
					if (load_we) begin
						if (task_in.last_task) begin
							n_q        <= count_new;
							count_q    <= '0;
							placed_q   <= '0;
							done_q     <= '0;
							progress_q <= 1'b0;
							cyc_q      <= 1'b0;
							i_q        <= '0;
							state_q    <= cps_pkg::ST_FSCAN;
						end else begin
							count_q <= count_new;
						end
					end
				end
				cps_pkg::ST_FSCAN: state_q <= cps_pkg::ST_FCHECK;
				cps_pkg::ST_FCHECK: begin
					k_q     <= '0;
					state_q <= eligible ? cps_pkg::ST_FWALK : cps_pkg::ST_FNEXT;
				end
				cps_pkg::ST_FWALK: begin
					if (k_last)
						state_q <= cps_pkg::ST_FWEND;
					else
						k_q <= k_q + IDX_W'(1);
				end
				cps_pkg::ST_FWEND: begin
					done_q[i_q] <= 1'b1;
					placed_q    <= placed_q + CNT_W'(1);
					progress_q  <= 1'b1;
					state_q     <= cps_pkg::ST_FNEXT;
				end
				cps_pkg::ST_FNEXT: begin
					if (placed_q == n_q) begin
						p_q     <= IDX_W'(n_q - CNT_W'(1));
						state_q <= cps_pkg::ST_BORD;
					end else if (!i_last) begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= cps_pkg::ST_FSCAN;
					end else if (progress_q) begin
						i_q        <= '0;
						progress_q <= 1'b0;
						state_q    <= cps_pkg::ST_FSCAN;
					end else begin
						// No task became ready in a whole pass: the rest lie on a cycle.
						cyc_q   <= 1'b1;
						i_q     <= '0;
						state_q <= cps_pkg::ST_OREAD;
					end
				end
				cps_pkg::ST_BORD: state_q <= cps_pkg::ST_BDUR;
				cps_pkg::ST_BDUR: begin
					k_q     <= '0;
					state_q <= cps_pkg::ST_BWALK;
				end
				cps_pkg::ST_BWALK: begin
					if (k_last)
						state_q <= cps_pkg::ST_BEND;
					else
						k_q <= k_q + IDX_W'(1);
				end
				cps_pkg::ST_BEND: begin
					if (p_q == '0) begin
						i_q     <= '0;
						state_q <= cps_pkg::ST_OREAD;
					end else begin
						p_q     <= p_q - IDX_W'(1);
						state_q <= cps_pkg::ST_BORD;
					end
				end
				cps_pkg::ST_OREAD: state_q <= cps_pkg::ST_OWAIT;
				cps_pkg::ST_OWAIT: begin
					if (out_load) begin
						if (i_last) begin
							state_q <= cps_pkg::ST_LOAD;
						end else begin
							i_q     <= i_q + IDX_W'(1);
							state_q <= cps_pkg::ST_OREAD;
						end
					end
				end
				default: state_q <= cps_pkg::ST_LOAD;
			endcase
		end
	end

	// Walk data registers.
	always_ff @(posedge clk) begin
		hit_s1 <= preds_q[k_q];
		unique case (state_q)
			cps_pkg::ST_FCHECK: begin
				preds_q <= preds_elig;
				dur_i_q <= dur_rd;
				acc_q   <= '0;
			end
			cps_pkg::ST_FWALK, cps_pkg::ST_BWALK, cps_pkg::ST_BEND: acc_q <= acc_next;
			cps_pkg::ST_FWEND: begin
				acc_q <= acc_next;
				if (ef_i > finish_q)
					finish_q <= ef_i;
			end
			cps_pkg::ST_BDUR: begin
				t_q   <= ord_rd;
				acc_q <= finish_q;
			end
			cps_pkg::ST_LOAD: finish_q <= '0;
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (result_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_task_q <= cps_pkg::INDEX_BITS'(i_q);
			out_est_q  <= cyc_q ? '0 : est_rd;
			out_lst_q  <= cyc_q ? '0 : lst_rd;
			out_fin_q  <= cyc_q ? '0 : finish_q;
			out_cyc_q  <= cyc_q;
			out_last_q <= i_last;
		end
	end

	assign result_out.valid          = out_v_q;
	assign result_out.out_task       = out_task_q;
	assign result_out.earliest_start = out_est_q;
	assign result_out.latest_start   = out_lst_q;
	assign result_out.project_finish = out_fin_q;
	assign result_out.cycle_error    = out_cyc_q;
	assign result_out.last_result    = out_last_q;

	`CPS_ASSERT(a_placed_bound, placed_q <= n_q, "more tasks placed than the project holds")
	`CPS_ASSERT(a_place_once, (state_q == cps_pkg::ST_FWEND) |-> !done_q[i_q], "task placed twice")
	`CPS_ASSERT(a_no_bwd_on_cycle, bwd_phase |-> !cyc_q, "backward pass on a cyclic project")
	`CPS_ASSERT_NEXT(a_back_to_load, out_load && i_last, state_q == cps_pkg::ST_LOAD, "no reload")

endmodule
